// ----- rtl/core/bounded_ordered_list_top_macros.svh -----
// assertion macros for the bounded ordered list
// used by bounded_ordered_list_top; no other dependencies
`ifndef BOUNDED_ORDERED_LIST_TOP_MACROS_SVH
`define BOUNDED_ORDERED_LIST_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define BOL_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent in the following cycle
`define BOL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
// condition never holds
`define BOL_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);
`else
`define BOL_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define BOL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`define BOL_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ----- rtl/core/bol_pkg.sv -----
// shared types and codes for the bounded ordered list
// no dependencies
package bol_pkg;

    // request kinds
    typedef enum logic [2:0] {
        REQ_HEAD = 3'd0,
        REQ_TAIL = 3'd1,
        REQ_POS  = 3'd2,
        REQ_SORT = 3'd3,
        REQ_READ = 3'd4
    } t_req;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_APPENDED = 2'd2,
        STAT_EMPTY    = 2'd3
    } t_status;

    // controller states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

    // field widths fixed by the interface
    localparam int unsigned REQ_W   = 3;
    localparam int unsigned POS_W   = 5;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 5;

    // command broadcast to every cell
    typedef struct packed {
        logic insert;
        logic rotate;
        t_req kind;
    } t_chain_ctl;

    // per-cell place flags, derived from cell index, fill count and target position
    typedef struct packed {
        logic first;
        logic occupied;
        logic at_tail;
        logic at_pos;
    } t_cell_flags;

endpackage

// ----- rtl/core/bol_cell.sv -----
// one cell of the list chain: holds one entry, decides insert point locally
// depends on bol_pkg
module bol_cell #(
    parameter int unsigned VW = 32
) (
    input  logic                   i_clk,
    input  bol_pkg::t_chain_ctl    i_ctl,
    input  bol_pkg::t_cell_flags   i_flags,
    input  logic [VW-1:0]          i_value,
    input  logic [VW-1:0]          i_left,
    input  logic [VW-1:0]          i_right,
    input  logic [VW-1:0]          i_head,
    input  logic                   i_found,
    output logic                   o_found,
    output logic [VW-1:0]          o_value
);

    logic [VW-1:0] r_value;
    logic [VW-1:0] n_value;
    logic          stop;

    // does the new item belong in this cell
    always_comb begin
        unique case (i_ctl.kind)
            bol_pkg::REQ_HEAD: stop = 1'b1;
            bol_pkg::REQ_TAIL: stop = !i_flags.occupied;
            bol_pkg::REQ_POS:  stop = !i_flags.occupied || i_flags.at_pos;
            bol_pkg::REQ_SORT: begin
                if (i_flags.first) begin
                    stop = !i_flags.occupied || ($signed(i_value) < $signed(r_value));
                end else begin
                    stop = !i_flags.occupied || !($signed(r_value) < $signed(i_value));
                end
            end
            default: stop = 1'b0;
        endcase
    end

    // insert point found here or further up the chain
    assign o_found = i_found | stop;

    // shift on insert, rotate on read-out
    always_comb begin
        n_value = r_value;
        if (i_ctl.insert) begin
            if (i_found) begin
                n_value = i_left;
            end else if (stop) begin
                n_value = i_value;
            end
        end else if (i_ctl.rotate) begin
            n_value = i_flags.at_tail ? i_head : i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ----- rtl/core/bol_chain.sv -----
// row of list cells with the insert-point ripple between neighbours
// depends on bol_pkg and bol_cell
module bol_chain #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned VW    = 32,
    parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
    input  logic                      i_clk,
    input  bol_pkg::t_chain_ctl       i_ctl,
    input  logic [CW-1:0]             i_count,
    input  logic [bol_pkg::POS_W-1:0] i_pos_idx,
    input  logic [VW-1:0]             i_value,
    output logic [VW-1:0]             o_head
);

    logic [VW-1:0] val [DEPTH];
    logic [DEPTH:0] found;

    assign found[0] = 1'b0;
    assign o_head   = val[0];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        bol_pkg::t_cell_flags flags;
        logic [VW-1:0] left;
        logic [VW-1:0] right;

        // place of this cell relative to fill count and target position
        assign flags.first    = (g == 0);
        assign flags.occupied = (g < int'(i_count));
        assign flags.at_tail  = ((g + 1) == int'(i_count));
        assign flags.at_pos   = (g == int'(i_pos_idx));

        if (g == 0) begin : g_left_first
            assign left = i_value;
        end else begin : g_left_mid
            assign left = val[g-1];
        end

        if (g == DEPTH - 1) begin : g_right_last
            assign right = val[0];
        end else begin : g_right_mid
            assign right = val[g+1];
        end

        bol_cell #(
            .VW (VW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (i_ctl),
            .i_flags (flags),
            .i_value (i_value),
            .i_left  (left),
            .i_right (right),
            .i_head  (val[0]),
            .i_found (found[g]),
            .o_found (found[g+1]),
            .o_value (val[g])
        );
    end

endmodule

// ----- rtl/core/bounded_ordered_list_top.sv -----
// Bounded ordered list: an accepted insert is written into the cell chain; its result is registered for the next cycle.
// Throughput: one insert item per cycle while no read-out runs and the result side is not stalled.
// A read holds off input while the chain rotates its entries past the head cell, giving one element
// per cycle while the result side is not stalled; an empty read answers at once.
// Reset (synchronous, active low) clears the fill count, controller and output valid;
// stored entries are left undefined and are only ever read below the fill count.
`include "bounded_ordered_list_top_macros.svh"
module bounded_ordered_list_top #(
    parameter int unsigned DEPTH       = 16,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [bol_pkg::REQ_W-1:0]     i_req_type,
    input  logic [bol_pkg::POS_W-1:0]     i_position,
    input  logic signed [bol_pkg::DATA_W-1:0] i_item_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_status,
    output logic signed [bol_pkg::DATA_W-1:0] o_read_value,
    output logic [bol_pkg::COUNT_W-1:0]   o_element_count,
    output logic                          o_last_result
);

    localparam int unsigned CW = $clog2(DEPTH + 1);

    bol_pkg::t_state     r_state;
    bol_pkg::t_state     n_state;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic [CW-1:0]       r_rd_left;
    logic [CW-1:0]       n_rd_left;

    logic                r_out_valid;
    bol_pkg::t_status    r_status;
    logic [bol_pkg::DATA_W-1:0] r_read_value;
    logic [CW-1:0]       r_count_out;
    logic                r_last;

    logic                adv;
    logic                accept;
    logic                full;
    logic                pos_past;
    logic [bol_pkg::POS_W-1:0] pos_idx;
    logic [63:0]         in_wide;
    logic [VALUE_WIDTH-1:0] new_val;
    logic [VALUE_WIDTH-1:0] head;
    logic [63:0]         head_wide;

    bol_pkg::t_chain_ctl ctl;
    logic                emit;
    logic                load_rd;
    logic                dec_rd;
    bol_pkg::t_status    res_status;
    logic [bol_pkg::DATA_W-1:0] res_value;
    logic                res_last;

    // handshake: a slot is free when the output register is empty or draining
    assign adv        = !r_out_valid || !i_out_stall;
    assign accept     = i_in_valid && i_rst_n && (r_state == bol_pkg::S_IDLE) && adv;
    assign o_in_stall = !(i_rst_n && (r_state == bol_pkg::S_IDLE) && adv);

    // operand preparation
    assign in_wide   = {32'd0, i_item_value};
    assign new_val   = in_wide[VALUE_WIDTH-1:0];
    assign head_wide = 64'(head);
    assign full      = (r_count == CW'(DEPTH));
    assign pos_idx   = (i_position == '0) ? '0 : (i_position - bol_pkg::POS_W'(1));
    assign pos_past  = (int'(pos_idx) > int'(r_count));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bol_pkg::S_IDLE: begin
                if (accept && (i_req_type == bol_pkg::REQ_READ) && (r_count != '0)) begin
                    n_state = bol_pkg::S_READ;
                end
            end
            bol_pkg::S_READ: begin
                if (adv && (r_rd_left == CW'(1))) begin
                    n_state = bol_pkg::S_IDLE;
                end
            end
            default: n_state = bol_pkg::S_IDLE;
        endcase
    end

    // controller outputs
    always_comb begin
        ctl.insert = 1'b0;
        ctl.rotate = 1'b0;
        ctl.kind   = bol_pkg::t_req'(i_req_type);
        emit       = 1'b0;
        load_rd    = 1'b0;
        dec_rd     = 1'b0;
        n_count    = r_count;
        res_status = bol_pkg::STAT_OK;
        res_value  = '0;
        res_last   = 1'b1;
        unique case (r_state)
            bol_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (i_req_type)
                        bol_pkg::REQ_READ: begin
                            if (r_count == '0) begin
                                emit       = 1'b1;
                                res_status = bol_pkg::STAT_EMPTY;
                            end else begin
                                load_rd = 1'b1;
                            end
                        end
                        bol_pkg::REQ_HEAD, bol_pkg::REQ_TAIL,
                        bol_pkg::REQ_POS, bol_pkg::REQ_SORT: begin
                            emit = 1'b1;
                            if (full) begin
                                res_status = bol_pkg::STAT_FULL;
                            end else begin
                                ctl.insert = 1'b1;
                                n_count    = r_count + CW'(1);
                                if ((i_req_type == bol_pkg::REQ_POS) && pos_past) begin
                                    res_status = bol_pkg::STAT_APPENDED;
                                end
                            end
                        end
                        default: emit = 1'b1;
                    endcase
                end
            end
            bol_pkg::S_READ: begin
                if (adv) begin
                    emit       = 1'b1;
                    ctl.rotate = 1'b1;
                    dec_rd     = 1'b1;
                    res_value  = head_wide[bol_pkg::DATA_W-1:0];
                    res_last   = (r_rd_left == CW'(1));
                end
            end
            default: emit = 1'b0;
        endcase
    end

    // read-out counter
    always_comb begin
        n_rd_left = r_rd_left;
        if (load_rd) begin
            n_rd_left = r_count;
        end else if (dec_rd) begin
            n_rd_left = r_rd_left - CW'(1);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bol_pkg::S_IDLE;
            r_count     <= '0;
            r_rd_left   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rd_left <= n_rd_left;
            if (adv) begin
                r_out_valid <= emit;
            end
        end
    end

    // result payload register
    always_ff @(posedge i_clk) begin
        if (adv && emit) begin
            r_status     <= res_status;
            r_read_value <= res_value;
            r_count_out  <= n_count;
            r_last       <= res_last;
        end
    end

    // cell chain
    bol_chain #(
        .DEPTH (DEPTH),
        .VW    (VALUE_WIDTH),
        .CW    (CW)
    ) u_chain (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_count   (r_count),
        .i_pos_idx (pos_idx),
        .i_value   (new_val),
        .o_head    (head)
    );

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_read_value    = r_read_value;
    assign o_element_count = bol_pkg::COUNT_W'(r_count_out);
    assign o_last_result   = r_last;

    // checks
    `BOL_ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, int'(r_count) > DEPTH, "fill count above depth")
    `BOL_ASSERT_NEXT(a_insert_count, i_clk, i_rst_n, ctl.insert, r_count == $past(r_count) + CW'(1), "insert did not grow list")
    `BOL_ASSERT_NEXT(a_read_start, i_clk, i_rst_n, load_rd, (r_state == bol_pkg::S_READ) && (r_rd_left == $past(r_count)), "read-out did not start")
    `BOL_ASSERT_NEXT(a_read_end, i_clk, i_rst_n, dec_rd && res_last, (r_state == bol_pkg::S_IDLE) && o_out_valid && o_last_result, "read-out did not finish on last item")

endmodule
